// File: design/mfd_pkg.sv
// shared types, codes and constants of the meter frame detector
package mfd_pkg;

  // default sizing
  localparam int ADDRESS_BYTES_DEF = 6;
  localparam int COUNT_WIDTH_DEF   = 16;

  // fixed field widths
  localparam int BYTE_W   = 8;
  localparam int CODE_W   = 3;
  localparam int FLEN_W   = 9;
  localparam int PRE_W    = 16;
  localparam int HDR_W    = 4;

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // protocol bytes
  localparam logic [BYTE_W-1:0] START_CODE = 8'h68;
  localparam logic [BYTE_W-1:0] END_CODE   = 8'h16;
  localparam logic [BYTE_W-1:0] WILDCARD   = 8'hAA;

  typedef enum logic [3:0] {
    PH_SEARCH = 4'd0,
    PH_ADDR   = 4'd1,
    PH_START2 = 4'd2,
    PH_CTRL   = 4'd3,
    PH_LEN    = 4'd4,
    PH_DATA   = 4'd5,
    PH_CSUM   = 4'd6,
    PH_END    = 4'd7
  } phase_t;

  typedef enum logic [CODE_W-1:0] {
    ST_SEARCHING = 3'd0,
    ST_INSIDE    = 3'd1,
    ST_GOOD      = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_BUF_ENDED = 3'd4
  } status_t;

  typedef enum logic [CODE_W-1:0] {
    RJ_NONE      = 3'd0,
    RJ_NO_START2 = 3'd1,
    RJ_BAD_ADDR  = 3'd2,
    RJ_CHECKSUM  = 3'd3,
    RJ_NO_END    = 3'd4
  } reason_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              buffer_last;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] status;
    logic [CODE_W-1:0] reject_reason;
    logic [FLEN_W-1:0] frame_length;
    logic [PRE_W-1:0]  preamble_count;
  } out_word_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              last;
    logic              is_start;
    logic              is_end;
    logic              is_wild;
    logic              is_bcd;
  } cls_word_t;

endpackage

// File: design/meter_frame_detector_top.sv
// Byte-serial DLT/645-2007 frame detector. One received byte per word enters on the in_ channel,
// and exactly one result word per byte leaves on the out_ channel, in order. The block sustains
// one byte per clock while the output side takes results: the front end classifies bytes into a
// two-entry queue, and the frame engine consumes one queued byte per cycle into a single output
// register, which holds the result for that byte until the output side takes it. Stalls on the
// output side back up through the queue to in_ready. There are no configuration registers; the
// address length and preamble counter width are set by parameters.
module meter_frame_detector_top #(
  parameter int ADDRESS_BYTES = mfd_pkg::ADDRESS_BYTES_DEF,
  parameter int COUNT_WIDTH   = mfd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mfd_pkg::in_word_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mfd_pkg::out_word_t    out_data
);

  logic                  q_valid;
  logic                  q_pop;
  mfd_pkg::cls_word_t    q_word;

  // byte classification and queue
  mfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_word   (q_word)
  );

  // frame engine
  mfd_back #(
    .ADDRESS_BYTES (ADDRESS_BYTES),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_word    (q_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: design/mfd_front.sv
// front end: byte classification and a short queue toward the frame engine
module mfd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mfd_pkg::in_word_t     in_data,
  output logic                  q_valid,
  input  logic                  q_pop,
  output mfd_pkg::cls_word_t    q_word
);

  mfd_pkg::cls_word_t                   cls_c;
  mfd_pkg::cls_word_t                   mem_r [mfd_pkg::QUEUE_DEPTH];
  logic [mfd_pkg::QUEUE_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [mfd_pkg::QUEUE_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [mfd_pkg::QUEUE_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                                 push;
  logic                                 pop;

  // classify the incoming word
  always_comb begin
    cls_c.rx_byte  = in_data.rx_byte;
    cls_c.last     = in_data.buffer_last;
    cls_c.is_start = (in_data.rx_byte == mfd_pkg::START_CODE);
    cls_c.is_end   = (in_data.rx_byte == mfd_pkg::END_CODE);
    cls_c.is_wild  = (in_data.rx_byte == mfd_pkg::WILDCARD);
    cls_c.is_bcd   = (in_data.rx_byte[7:4] <= 4'd9) && (in_data.rx_byte[3:0] <= 4'd9);
  end

  // queue bookkeeping
  assign in_ready = (cnt_r != mfd_pkg::QUEUE_CNT_W'(mfd_pkg::QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_word   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + mfd_pkg::QUEUE_CNT_W'(push) - mfd_pkg::QUEUE_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls_c;
    end
  end

endmodule

// File: design/mfd_back.sv
// back end: frame tracking state machine and output register
module mfd_back #(
  parameter int ADDRESS_BYTES = mfd_pkg::ADDRESS_BYTES_DEF,
  parameter int COUNT_WIDTH   = mfd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  mfd_pkg::cls_word_t    q_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mfd_pkg::out_word_t    out_data
);

  localparam int SUM_W = ((COUNT_WIDTH > mfd_pkg::FLEN_W) ? COUNT_WIDTH : mfd_pkg::FLEN_W) + 1;
  localparam logic [SUM_W-1:0] CNT_MAX = SUM_W'({COUNT_WIDTH{1'b1}});
  localparam logic [mfd_pkg::HDR_W-1:0] ADDR_LAST = mfd_pkg::HDR_W'(ADDRESS_BYTES);
  localparam logic [mfd_pkg::FLEN_W-1:0] FRAME_OVH = mfd_pkg::FLEN_W'(ADDRESS_BYTES + 6);

  mfd_pkg::phase_t                 phase_r, phase_nxt;
  logic [mfd_pkg::HDR_W-1:0]       hdr_pos_r, hdr_pos_nxt;
  logic                            wild_seen_r, wild_seen_nxt;
  logic [mfd_pkg::BYTE_W-1:0]      sum_r, sum_nxt;
  logic [mfd_pkg::BYTE_W-1:0]      data_len_r, data_len_nxt;
  logic [mfd_pkg::BYTE_W-1:0]      data_rem_r, data_rem_nxt;
  logic [COUNT_WIDTH-1:0]          skipped_r, skipped_nxt;
  logic                            out_valid_r;
  mfd_pkg::out_word_t              out_data_r, out_word_c;

  logic                            fire;
  mfd_pkg::reason_t                reason_c;
  logic                            good_c;
  logic [mfd_pkg::BYTE_W-1:0]      sum_plus_c;
  logic [mfd_pkg::FLEN_W-1:0]      cand_c;
  logic [mfd_pkg::FLEN_W-1:0]      add_n_c;
  logic [SUM_W-1:0]                sat_sum_c;
  logic [COUNT_WIDTH-1:0]          skipped_add_c;
  mfd_pkg::status_t                status_c;

  // take a word whenever the output register is free or being drained
  assign fire      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks on the current byte
  always_comb begin
    reason_c   = mfd_pkg::RJ_NONE;
    cand_c     = mfd_pkg::FLEN_W'(1);
    sum_plus_c = sum_r + q_word.rx_byte;
    case (phase_r)
      mfd_pkg::PH_ADDR: begin
        cand_c = mfd_pkg::FLEN_W'(hdr_pos_r) + mfd_pkg::FLEN_W'(2);
        if (!q_word.is_wild && (!q_word.is_bcd || wild_seen_r)) begin
          reason_c = mfd_pkg::RJ_BAD_ADDR;
        end
      end
      mfd_pkg::PH_START2: begin
        cand_c = mfd_pkg::FLEN_W'(ADDRESS_BYTES + 2);
        if (!q_word.is_start) begin
          reason_c = mfd_pkg::RJ_NO_START2;
        end
      end
      mfd_pkg::PH_CSUM: begin
        cand_c = mfd_pkg::FLEN_W'(ADDRESS_BYTES + 5) + mfd_pkg::FLEN_W'(data_len_r);
        if (q_word.rx_byte != sum_r) begin
          reason_c = mfd_pkg::RJ_CHECKSUM;
        end
      end
      mfd_pkg::PH_END: begin
        cand_c = FRAME_OVH + mfd_pkg::FLEN_W'(data_len_r);
        if (!q_word.is_end) begin
          reason_c = mfd_pkg::RJ_NO_END;
        end
      end
      default: begin
        cand_c = mfd_pkg::FLEN_W'(1);
      end
    endcase
    good_c = (phase_r == mfd_pkg::PH_END) && q_word.is_end;
  end

  // saturating preamble count update
  always_comb begin
    if (reason_c != mfd_pkg::RJ_NONE) begin
      add_n_c = cand_c;
    end else if ((phase_r == mfd_pkg::PH_SEARCH) && !q_word.is_start) begin
      add_n_c = mfd_pkg::FLEN_W'(1);
    end else begin
      add_n_c = '0;
    end
    sat_sum_c = SUM_W'(skipped_r) + SUM_W'(add_n_c);
    if (sat_sum_c >= CNT_MAX) begin
      skipped_add_c = CNT_MAX[COUNT_WIDTH-1:0];
    end else begin
      skipped_add_c = sat_sum_c[COUNT_WIDTH-1:0];
    end
  end

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    hdr_pos_nxt   = hdr_pos_r;
    wild_seen_nxt = wild_seen_r;
    sum_nxt       = sum_r;
    data_len_nxt  = data_len_r;
    data_rem_nxt  = data_rem_r;
    skipped_nxt   = skipped_add_c;
    case (phase_r)
      mfd_pkg::PH_SEARCH: begin
        if (q_word.is_start) begin
          phase_nxt     = mfd_pkg::PH_ADDR;
          hdr_pos_nxt   = '0;
          wild_seen_nxt = 1'b0;
          sum_nxt       = q_word.rx_byte;
        end
      end
      mfd_pkg::PH_ADDR: begin
        if (reason_c == mfd_pkg::RJ_NONE) begin
          if (q_word.is_wild) begin
            wild_seen_nxt = 1'b1;
          end
          sum_nxt     = sum_plus_c;
          hdr_pos_nxt = hdr_pos_r + 1'b1;
          if ((hdr_pos_r + 1'b1) >= ADDR_LAST) begin
            phase_nxt = mfd_pkg::PH_START2;
          end
        end
      end
      mfd_pkg::PH_START2: begin
        if (reason_c == mfd_pkg::RJ_NONE) begin
          sum_nxt   = sum_plus_c;
          phase_nxt = mfd_pkg::PH_CTRL;
        end
      end
      mfd_pkg::PH_CTRL: begin
        sum_nxt   = sum_plus_c;
        phase_nxt = mfd_pkg::PH_LEN;
      end
      mfd_pkg::PH_LEN: begin
        sum_nxt      = sum_plus_c;
        data_len_nxt = q_word.rx_byte;
        data_rem_nxt = q_word.rx_byte;
        phase_nxt    = (q_word.rx_byte == '0) ? mfd_pkg::PH_CSUM : mfd_pkg::PH_DATA;
      end
      mfd_pkg::PH_DATA: begin
        sum_nxt      = sum_plus_c;
        data_rem_nxt = data_rem_r - 1'b1;
        if (data_rem_r == mfd_pkg::BYTE_W'(1)) begin
          phase_nxt = mfd_pkg::PH_CSUM;
        end
      end
      mfd_pkg::PH_CSUM: begin
        if (reason_c == mfd_pkg::RJ_NONE) begin
          phase_nxt = mfd_pkg::PH_END;
        end
      end
      default: begin
      end
    endcase
    // restart after a good frame, a rejection or the end of the buffer
    if (good_c || (reason_c != mfd_pkg::RJ_NONE) || q_word.last) begin
      phase_nxt     = mfd_pkg::PH_SEARCH;
      hdr_pos_nxt   = '0;
      wild_seen_nxt = 1'b0;
      sum_nxt       = '0;
      data_len_nxt  = '0;
      data_rem_nxt  = '0;
    end
    if (good_c || q_word.last) begin
      skipped_nxt = '0;
    end
  end

  // result word
  always_comb begin
    if (reason_c != mfd_pkg::RJ_NONE) begin
      status_c = mfd_pkg::ST_REJECTED;
    end else if (good_c) begin
      status_c = mfd_pkg::ST_GOOD;
    end else if ((phase_r == mfd_pkg::PH_SEARCH) && !q_word.is_start) begin
      status_c = mfd_pkg::ST_SEARCHING;
    end else begin
      status_c = mfd_pkg::ST_INSIDE;
    end
    if (q_word.last && (status_c != mfd_pkg::ST_GOOD) && (status_c != mfd_pkg::ST_REJECTED)) begin
      status_c = mfd_pkg::ST_BUF_ENDED;
    end
    out_word_c.status         = status_c;
    out_word_c.reject_reason  = reason_c;
    out_word_c.frame_length   = good_c ? FRAME_OVH + mfd_pkg::FLEN_W'(data_len_r) : '0;
    out_word_c.preamble_count = good_c ? mfd_pkg::PRE_W'(skipped_r) : '0;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= mfd_pkg::PH_SEARCH;
      hdr_pos_r   <= '0;
      wild_seen_r <= 1'b0;
      sum_r       <= '0;
      data_len_r  <= '0;
      data_rem_r  <= '0;
      skipped_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r     <= phase_nxt;
        hdr_pos_r   <= hdr_pos_nxt;
        wild_seen_r <= wild_seen_nxt;
        sum_r       <= sum_nxt;
        data_len_r  <= data_len_nxt;
        data_rem_r  <= data_rem_nxt;
        skipped_r   <= skipped_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_word_c;
    end
  end

`ifndef NO_ASSERTIONS
  // header position stays inside the address field while collecting it
  a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == mfd_pkg::PH_ADDR) |-> (hdr_pos_r < ADDR_LAST))
    else $error("header position out of range");

  // a reason is reported only with a rejection
  a_reason_only_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != mfd_pkg::ST_REJECTED))
      |-> (out_data_r.reject_reason == mfd_pkg::RJ_NONE))
    else $error("reject reason without rejection");

  // a good frame always carries at least the fixed overhead
  a_good_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == mfd_pkg::ST_GOOD))
      |-> (out_data_r.frame_length >= FRAME_OVH))
    else $error("good frame too short");

  // buffer end returns the scan state to search with a cleared count
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && q_word.last) |=> ((phase_r == mfd_pkg::PH_SEARCH) && (skipped_r == '0)))
    else $error("scan state not reset after buffer end");
`endif

endmodule

// File: verif/meter_frame_detector_top_test.sv
// testbench of meter_frame_detector_top: frame streams checked against a behavioral predictor
module meter_frame_detector_top_test;

  localparam int ADDR_BYTES   = mfd_pkg::ADDRESS_BYTES_DEF;
  localparam int unsigned SKIP_MAX = (1 << mfd_pkg::COUNT_WIDTH_DEF) - 1;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int QUIET_ITEMS  = 150;

  // ways a generated frame can be damaged
  typedef enum int {
    FT_NONE, FT_ADDR, FT_WILD_ORDER, FT_START2, FT_CSUM, FT_END, FT_CUT
  } fault_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  mfd_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  mfd_pkg::out_word_t out_data;

  // shared run state
  mfd_pkg::out_word_t expected_words[$];
  int unsigned error_count = 0;
  int unsigned words_sent = 0;
  bit          gaps_on = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  // predictor state
  mfd_pkg::phase_t pr_phase = mfd_pkg::PH_SEARCH;
  logic [3:0]  pr_hdr_pos = '0;
  logic        pr_wild = 1'b0;
  logic [7:0]  pr_sum = '0;
  logic [7:0]  pr_dlen = '0;
  logic [7:0]  pr_drem = '0;
  int unsigned pr_skipped = 0;

  meter_frame_detector_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // saturating preamble counter
  function automatic void add_skipped(int unsigned n);
    if (pr_skipped >= SKIP_MAX || n >= SKIP_MAX - pr_skipped) begin
      pr_skipped = SKIP_MAX;
    end else begin
      pr_skipped = pr_skipped + n;
    end
  endfunction

  function automatic void restart_search();
    pr_phase   = mfd_pkg::PH_SEARCH;
    pr_hdr_pos = '0;
    pr_wild    = 1'b0;
    pr_sum     = '0;
    pr_dlen    = '0;
    pr_drem    = '0;
  endfunction

  // next frame-engine result for one byte, advancing the predictor state
  function automatic mfd_pkg::out_word_t predict_status(mfd_pkg::in_word_t w);
    logic [7:0]         b;
    mfd_pkg::status_t   st;
    mfd_pkg::reason_t   rj;
    logic [8:0]         flen;
    logic [15:0]        pre;
    int unsigned        cand;
    mfd_pkg::out_word_t r;
    b    = w.rx_byte;
    st   = mfd_pkg::ST_SEARCHING;
    rj   = mfd_pkg::RJ_NONE;
    flen = '0;
    pre  = '0;
    cand = 1;
    case (pr_phase)
      mfd_pkg::PH_SEARCH: begin
        if (b == mfd_pkg::START_CODE) begin
          pr_phase   = mfd_pkg::PH_ADDR;
          pr_hdr_pos = '0;
          pr_wild    = 1'b0;
          pr_sum     = b;
          st         = mfd_pkg::ST_INSIDE;
        end else begin
          add_skipped(1);
        end
      end
      mfd_pkg::PH_ADDR: begin
        if (b == mfd_pkg::WILDCARD) begin
          pr_wild = 1'b1;
        end else if (b[7:4] > 4'd9 || b[3:0] > 4'd9 || pr_wild) begin
          rj = mfd_pkg::RJ_BAD_ADDR;
        end
        if (rj == mfd_pkg::RJ_NONE) begin
          pr_sum     = pr_sum + b;
          pr_hdr_pos = pr_hdr_pos + 4'd1;
          if (pr_hdr_pos >= ADDR_BYTES) pr_phase = mfd_pkg::PH_START2;
          st = mfd_pkg::ST_INSIDE;
        end else begin
          cand = pr_hdr_pos + 2;
        end
      end
      mfd_pkg::PH_START2: begin
        if (b != mfd_pkg::START_CODE) begin
          rj   = mfd_pkg::RJ_NO_START2;
          cand = ADDR_BYTES + 2;
        end else begin
          pr_sum   = pr_sum + b;
          pr_phase = mfd_pkg::PH_CTRL;
          st       = mfd_pkg::ST_INSIDE;
        end
      end
      mfd_pkg::PH_CTRL: begin
        pr_sum   = pr_sum + b;
        pr_phase = mfd_pkg::PH_LEN;
        st       = mfd_pkg::ST_INSIDE;
      end
      mfd_pkg::PH_LEN: begin
        pr_sum   = pr_sum + b;
        pr_dlen  = b;
        pr_drem  = b;
        pr_phase = (b == 8'd0) ? mfd_pkg::PH_CSUM : mfd_pkg::PH_DATA;
        st       = mfd_pkg::ST_INSIDE;
      end
      mfd_pkg::PH_DATA: begin
        pr_sum  = pr_sum + b;
        pr_drem = pr_drem - 8'd1;
        if (pr_drem == 8'd0) pr_phase = mfd_pkg::PH_CSUM;
        st = mfd_pkg::ST_INSIDE;
      end
      mfd_pkg::PH_CSUM: begin
        if (b != pr_sum) begin
          rj   = mfd_pkg::RJ_CHECKSUM;
          cand = ADDR_BYTES + 5 + pr_dlen;
        end else begin
          pr_phase = mfd_pkg::PH_END;
          st       = mfd_pkg::ST_INSIDE;
        end
      end
      default: begin
        if (b != mfd_pkg::END_CODE) begin
          rj   = mfd_pkg::RJ_NO_END;
          cand = ADDR_BYTES + 6 + pr_dlen;
        end else begin
          st   = mfd_pkg::ST_GOOD;
          flen = 9'(ADDR_BYTES + 6 + pr_dlen);
          pre  = pr_skipped[15:0];
          restart_search();
          pr_skipped = 0;
        end
      end
    endcase
    // rejected candidate counts as preamble, search starts again
    if (rj != mfd_pkg::RJ_NONE) begin
      add_skipped(cand);
      restart_search();
      st = mfd_pkg::ST_REJECTED;
    end
    // buffer end clears all scan state
    if (w.buffer_last) begin
      if (st != mfd_pkg::ST_GOOD && st != mfd_pkg::ST_REJECTED) begin
        st   = mfd_pkg::ST_BUF_ENDED;
        rj   = mfd_pkg::RJ_NONE;
        flen = '0;
        pre  = '0;
      end
      restart_search();
      pr_skipped = 0;
    end
    r.status         = st;
    r.reject_reason  = rj;
    r.frame_length   = flen;
    r.preamble_count = pre;
    return r;
  endfunction

  // send one word, with an optional gap before it
  task automatic send_word(logic [7:0] b, logic last);
    mfd_pkg::in_word_t w;
    w.rx_byte     = b;
    w.buffer_last = last;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_words.push_back(predict_status(w));
    words_sent++;
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == mfd_pkg::START_CODE) b = 8'h00;
    return b;
  endfunction

  function automatic logic [7:0] bcd_byte();
    logic [3:0] hi;
    logic [3:0] lo;
    hi = 4'($urandom_range(0, 9));
    lo = 4'($urandom_range(0, 9));
    return {hi, lo};
  endfunction

  // preamble, then one frame, sent up to the damaged byte or the cut
  task automatic send_frame(int unsigned n_pre, int unsigned len, fault_t fault, bit end_buffer);
    logic [7:0]  frame_q[$];
    logic [7:0]  b;
    logic [7:0]  csum;
    int unsigned wild_from;
    int unsigned pos;
    int unsigned stop_at;
    for (int i = 0; i < n_pre; i++) send_word(noise_byte(), 1'b0);
    wild_from = $urandom_range(0, 1) ? ADDR_BYTES : $urandom_range(0, ADDR_BYTES - 1);
    frame_q.push_back(mfd_pkg::START_CODE);
    for (int i = 0; i < ADDR_BYTES; i++) begin
      frame_q.push_back((i >= wild_from) ? mfd_pkg::WILDCARD : bcd_byte());
    end
    frame_q.push_back(mfd_pkg::START_CODE);
    frame_q.push_back(8'($urandom_range(0, 255)));
    frame_q.push_back(len[7:0]);
    for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom_range(0, 255)));
    stop_at = ADDR_BYTES + 5 + len;
    // header damage
    case (fault)
      FT_ADDR: begin
        pos = $urandom_range(1, ADDR_BYTES);
        do begin
          b = 8'($urandom_range(0, 255));
        end while ((b[7:4] <= 4'd9 && b[3:0] <= 4'd9) || b == mfd_pkg::WILDCARD);
        frame_q[pos] = b;
        stop_at = pos;
      end
      FT_WILD_ORDER: begin
        pos = $urandom_range(2, ADDR_BYTES);
        frame_q[pos - 1] = mfd_pkg::WILDCARD;
        frame_q[pos]     = bcd_byte();
        stop_at = pos;
      end
      FT_START2: begin
        frame_q[ADDR_BYTES + 1] = noise_byte();
        stop_at = ADDR_BYTES + 1;
      end
      default: ;
    endcase
    csum = '0;
    foreach (frame_q[i]) csum = csum + frame_q[i];
    if (fault == FT_CSUM) begin
      csum    = csum + 8'($urandom_range(1, 255));
      stop_at = ADDR_BYTES + 4 + len;
    end
    frame_q.push_back(csum);
    b = mfd_pkg::END_CODE;
    if (fault == FT_END) begin
      do b = 8'($urandom_range(0, 255)); while (b == mfd_pkg::END_CODE);
    end
    frame_q.push_back(b);
    if (fault == FT_CUT) stop_at = $urandom_range(0, frame_q.size() - 1);
    for (int i = 0; i <= stop_at; i++) begin
      send_word(frame_q[i], (i == stop_at) && (end_buffer || fault == FT_CUT));
    end
  endtask

  // a good frame after a short preamble, its address possibly ending in wildcards
  task automatic test_good_frame();
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_frame(0, 0, FT_NONE, 1'b0);
  endtask

  // each header rejection reached directly
  task automatic test_header_rejects();
    send_word(mfd_pkg::START_CODE, 1'b0);
    send_word(8'h9A, 1'b0);
    send_word(mfd_pkg::START_CODE, 1'b0);
    send_word(mfd_pkg::WILDCARD, 1'b0);
    send_word(8'h99, 1'b0);
    send_frame(0, 0, FT_START2, 1'b0);
  endtask

  // frame cut off by the end of the buffer
  task automatic test_buffer_end();
    send_word(mfd_pkg::START_CODE, 1'b0);
    send_word(8'h12, 1'b1);
  endtask

  // longest data field, frame ending the buffer
  task automatic test_max_length();
    send_frame(1, 255, FT_NONE, 1'b1);
  endtask

  // long preamble ahead of a frame, then a short one
  task automatic test_long_preamble();
    gaps_on = 1'b0;
    for (int i = 0; i < 40; i++) send_word(noise_byte(), 1'b0);
    send_frame(0, 2, FT_NONE, 1'b0);
    send_frame(3, 1, FT_NONE, 1'b0);
  endtask

  // mostly well-formed frames with random damage, noise and gaps
  task automatic test_random_traffic();
    int unsigned stop_count;
    int unsigned len;
    fault_t      fault;
    stop_count = words_sent + RANDOM_ITEMS;
    while (words_sent < stop_count) begin
      gaps_on = (words_sent + QUIET_ITEMS < stop_count) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_word(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
      end else begin
        len   = ($urandom_range(0, 49) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 8);
        fault = ($urandom_range(0, 9) < 6) ? FT_NONE : fault_t'($urandom_range(1, 6));
        send_frame($urandom_range(0, 3), len, fault, $urandom_range(0, 7) == 0);
      end
    end
    gaps_on = 1'b0;
  endtask

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    mfd_pkg::out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
        error_count++;
      end else begin
        exp_w = expected_words.pop_front();
        check_field("status", exp_w.status, out_data.status);
        check_field("reject_reason", exp_w.reject_reason, out_data.reject_reason);
        check_field("frame_length", exp_w.frame_length, out_data.frame_length);
        check_field("preamble_count", exp_w.preamble_count, out_data.preamble_count);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_good_frame();
    test_header_rejects();
    test_buffer_end();
    test_max_length();
    test_random_traffic();
    test_long_preamble();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/mfd_pkg.sv
design/mfd_front.sv
design/mfd_back.sv
design/meter_frame_detector_top.sv
verif/meter_frame_detector_top_test.sv
